/* rtl/kpu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpu_pkg
// shared types, constants, factorial table and microcode for the unranking unit
// ----------------------------------------------------------------------------
package kpu_pkg;

    localparam int MAX_LENGTH_DEF = 12;
    localparam int VAL_W          = 4;
    localparam int RANK_W         = 31;
    localparam int FACT_W         = 32;
    localparam int DIV_W          = FACT_W + 4;
    localparam int STEP_W         = 3;

    typedef logic [STEP_W-1:0] step_t;

    // program addresses
    localparam step_t STEP_TAKE = 3'd0;
    localparam step_t STEP_DIV3 = 3'd1;
    localparam step_t STEP_DIV2 = 3'd2;
    localparam step_t STEP_DIV1 = 3'd3;
    localparam step_t STEP_DIV0 = 3'd4;
    localparam step_t STEP_EMIT = 3'd5;
    localparam step_t STEP_WRAP = 3'd6;

    typedef enum logic [1:0] {
        JC_NEXT     = 2'd0,
        JC_ALWAYS   = 2'd1,
        JC_NO_START = 2'd2,
        JC_MORE     = 2'd3
    } jcond_t;

    typedef struct packed {
        logic       take;
        logic       div_en;
        logic [1:0] div_shift;
        logic       emit;
        logic       wait_out;
        jcond_t     cond;
        step_t      target;
    } ctrl_word_t;

    typedef struct packed {
        logic       load;
        logic       div_en;
        logic [1:0] div_shift;
        logic       emit;
    } dp_ctrl_t;

    typedef struct packed {
        logic start_ok;
        logic more;
        logic out_busy;
    } dp_status_t;

    function automatic logic [FACT_W-1:0] fact(input logic [VAL_W-1:0] idx);
        logic [FACT_W-1:0] f;
        case (idx)
            4'd0:    f = 32'd1;
            4'd1:    f = 32'd1;
            4'd2:    f = 32'd2;
            4'd3:    f = 32'd6;
            4'd4:    f = 32'd24;
            4'd5:    f = 32'd120;
            4'd6:    f = 32'd720;
            4'd7:    f = 32'd5040;
            4'd8:    f = 32'd40320;
            4'd9:    f = 32'd362880;
            4'd10:   f = 32'd3628800;
            4'd11:   f = 32'd39916800;
            default: f = 32'd479001600;
        endcase
        return f;
    endfunction

    // control store: take, four restoring division steps, emit, wrap
    function automatic ctrl_word_t ucode(input step_t step);
        ctrl_word_t cw;
        cw = '{take: 1'b0, div_en: 1'b0, div_shift: 2'd0, emit: 1'b0,
               wait_out: 1'b0, cond: JC_ALWAYS, target: STEP_TAKE};
        case (step)
            STEP_TAKE:
            begin
                cw.take   = 1'b1;
                cw.cond   = JC_NO_START;
                cw.target = STEP_TAKE;
            end
            STEP_DIV3:
            begin
                cw.div_en    = 1'b1;
                cw.div_shift = 2'd3;
                cw.cond      = JC_NEXT;
            end
            STEP_DIV2:
            begin
                cw.div_en    = 1'b1;
                cw.div_shift = 2'd2;
                cw.cond      = JC_NEXT;
            end
            STEP_DIV1:
            begin
                cw.div_en    = 1'b1;
                cw.div_shift = 2'd1;
                cw.cond      = JC_NEXT;
            end
            STEP_DIV0:
            begin
                cw.div_en    = 1'b1;
                cw.div_shift = 2'd0;
                cw.cond      = JC_NEXT;
            end
            STEP_EMIT:
            begin
                cw.emit     = 1'b1;
                cw.wait_out = 1'b1;
                cw.cond     = JC_MORE;
                cw.target   = STEP_DIV3;
            end
            STEP_WRAP:
            begin
                cw.cond   = JC_ALWAYS;
                cw.target = STEP_TAKE;
            end
            default:
            begin
                cw.cond   = JC_ALWAYS;
                cw.target = STEP_TAKE;
            end
        endcase
        return cw;
    endfunction

endpackage

/* rtl/kth_permutation_unrank.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kth_permutation_unrank
// emits the k-th lexicographic permutation of 1..n, one element per transaction
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   cfg     | in        | cfg_valid/ready    | cfg_data (perm_length)
//   in      | in        | in_valid/in_stall  | rank
//   out     | out       | out_valid/stall    | element_value, position, last
//
// a microcoded sequencer runs four restoring division steps and one emit step
// per element, with a take step before the first element and a wrap step after
// the last. a rank of zero or above n! is consumed at the take step and gives
// nothing. reset sets perm_length to 1.
// output stall holds the emit step; input is taken only at the take step.
// ----------------------------------------------------------------------------
module kth_permutation_unrank #(
    parameter int MAX_LENGTH = kpu_pkg::MAX_LENGTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kpu_pkg::VAL_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [kpu_pkg::RANK_W-1:0]     rank,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [kpu_pkg::VAL_W-1:0]      element_value,
    output logic [kpu_pkg::VAL_W-1:0]      position,
    output logic                           last
);

    logic [kpu_pkg::VAL_W-1:0] perm_length_reg;
    kpu_pkg::step_t            step_reg, step_next;
    kpu_pkg::ctrl_word_t       cw;
    kpu_pkg::dp_ctrl_t         ctrl;
    kpu_pkg::dp_status_t       status;
    logic                      hold;
    logic                      jump;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            perm_length_reg <= 4'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            perm_length_reg <= cfg_data;
        end
    end

    // sequencer
    assign cw       = kpu_pkg::ucode(step_reg);
    assign hold     = cw.wait_out && status.out_busy;
    assign in_stall = !cw.take;

    assign ctrl.load      = cw.take && in_valid && status.start_ok;
    assign ctrl.div_en    = cw.div_en;
    assign ctrl.div_shift = cw.div_shift;
    assign ctrl.emit      = cw.emit && !hold;

    always_comb
    begin
        case (cw.cond)
            kpu_pkg::JC_NEXT:     jump = 1'b0;
            kpu_pkg::JC_ALWAYS:   jump = 1'b1;
            kpu_pkg::JC_NO_START: jump = !(in_valid && status.start_ok);
            kpu_pkg::JC_MORE:     jump = status.more;
            default:              jump = 1'b1;
        endcase

        if (hold)
        begin
            step_next = step_reg;
        end
        else if (jump)
        begin
            step_next = cw.target;
        end
        else
        begin
            step_next = step_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= kpu_pkg::STEP_TAKE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    kpu_datapath #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .status        (status),
        .perm_length   (perm_length_reg),
        .rank          (rank),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .element_value (element_value),
        .position      (position),
        .last          (last)
    );

endmodule

/* rtl/kpu_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpu_datapath
// remainder, digit, remaining-value list and output register of the unranker
// ----------------------------------------------------------------------------
module kpu_datapath #(
    parameter int MAX_LENGTH = kpu_pkg::MAX_LENGTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  kpu_pkg::dp_ctrl_t              ctrl,
    output kpu_pkg::dp_status_t            status,
    input  logic [kpu_pkg::VAL_W-1:0]      perm_length,
    input  logic [kpu_pkg::RANK_W-1:0]     rank,
    input  logic                           out_stall,
    output logic                           out_valid,
    output logic [kpu_pkg::VAL_W-1:0]      element_value,
    output logic [kpu_pkg::VAL_W-1:0]      position,
    output logic                           last
);

    localparam int IDX_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam logic [kpu_pkg::VAL_W-1:0] MAX_N = kpu_pkg::VAL_W'(MAX_LENGTH);

    logic [kpu_pkg::VAL_W-1:0]  n_eff;
    logic [kpu_pkg::FACT_W-1:0] n_fact;

    logic [kpu_pkg::VAL_W-1:0]  n_reg, n_next;
    logic [kpu_pkg::VAL_W-1:0]  p_reg, p_next;
    logic [kpu_pkg::RANK_W-1:0] r_reg, r_next;
    logic [kpu_pkg::VAL_W-1:0]  digit_reg, digit_next;
    logic [kpu_pkg::VAL_W-1:0]  list_reg  [MAX_LENGTH];
    logic [kpu_pkg::VAL_W-1:0]  list_next [MAX_LENGTH];

    logic                       out_valid_reg, out_valid_next;
    logic [kpu_pkg::VAL_W-1:0]  value_reg, value_next;
    logic [kpu_pkg::VAL_W-1:0]  pos_reg, pos_next;
    logic                       last_reg, last_next;

    logic [kpu_pkg::VAL_W-1:0]  f_idx;
    logic [kpu_pkg::DIV_W-1:0]  f_shifted;
    logic [kpu_pkg::DIV_W-1:0]  r_wide;
    logic                       is_last;
    logic [IDX_W-1:0]           sel;
    logic [kpu_pkg::VAL_W-1:0]  pick;

    assign n_eff  = (perm_length > MAX_N) ? MAX_N : perm_length;
    assign n_fact = kpu_pkg::fact(n_eff);

    assign status.start_ok = (n_eff != '0) && (rank != '0)
                             && ({1'b0, rank} <= n_fact);
    assign is_last         = (p_reg == (n_reg - 4'd1));
    assign status.more     = !is_last;
    assign status.out_busy = out_valid_reg && out_stall;

    assign f_idx     = n_reg - 4'd1 - p_reg;
    assign f_shifted = {4'd0, kpu_pkg::fact(f_idx)} << ctrl.div_shift;
    assign r_wide    = {{(kpu_pkg::DIV_W - kpu_pkg::RANK_W){1'b0}}, r_reg};
    assign sel       = digit_reg[IDX_W-1:0];
    assign pick      = list_reg[sel];

    always_comb
    begin
        n_next         = n_reg;
        p_next         = p_reg;
        r_next         = r_reg;
        digit_next     = digit_reg;
        list_next      = list_reg;
        out_valid_next = out_valid_reg && out_stall;
        value_next     = value_reg;
        pos_next       = pos_reg;
        last_next      = last_reg;

        if (ctrl.load)
        begin
            n_next     = n_eff;
            p_next     = '0;
            r_next     = rank - 31'd1;
            digit_next = '0;
            for (int i = 0; i < MAX_LENGTH; i++)
            begin
                list_next[i] = kpu_pkg::VAL_W'(i + 1);
            end
        end

        if (ctrl.div_en && (r_wide >= f_shifted))
        begin
            r_next = r_reg - f_shifted[kpu_pkg::RANK_W-1:0];
            digit_next[ctrl.div_shift] = 1'b1;
        end

        if (ctrl.emit)
        begin
            out_valid_next = 1'b1;
            value_next     = pick;
            pos_next       = p_reg;
            last_next      = is_last;
            p_next         = p_reg + 4'd1;
            digit_next     = '0;
            // close the gap left by the picked value
            for (int i = 0; i < MAX_LENGTH - 1; i++)
            begin
                if (IDX_W'(i) >= sel)
                begin
                    list_next[i] = list_reg[i + 1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        p_reg     <= p_next;
        r_reg     <= r_next;
        digit_reg <= digit_next;
        list_reg  <= list_next;
        value_reg <= value_next;
        pos_reg   <= pos_next;
        last_reg  <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign element_value = value_reg;
    assign position      = pos_reg;
    assign last          = last_reg;

endmodule

/* dv/kpu_unrank_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpu_unrank_checker
// Watches the config, rank and element channels of the unranking unit. Each
// accepted rank is unranked in the factorial number system against the current
// length setting. The expected elements are queued, and each element
// transaction is compared field by field with the oldest one. It reports the
// mismatch count, the number of elements still due and the number checked.
// ----------------------------------------------------------------------------
module kpu_unrank_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [kpu_pkg::VAL_W-1:0]      cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [kpu_pkg::RANK_W-1:0]     rank,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [kpu_pkg::VAL_W-1:0]      element_value,
    input  logic [kpu_pkg::VAL_W-1:0]      position,
    input  logic                           last,
    output int                             mismatches,
    output int                             pending,
    output int                             elements_checked
);

    typedef struct packed {
        logic [kpu_pkg::VAL_W-1:0] element_value;
        logic [kpu_pkg::VAL_W-1:0] position;
        logic                      is_last;
    } perm_element_t;

    perm_element_t             due_elements[$];
    perm_element_t             want;
    logic [kpu_pkg::VAL_W-1:0] length_setting;
    int                        fail_count;
    int                        due_count;
    int                        checked_count;

    assign mismatches       = fail_count;
    assign pending          = due_count;
    assign elements_checked = checked_count;

    task automatic report_mismatch(input string what);
        $display("[%0t] element check failed: %s", $time, what);
        fail_count++;
    endtask

    // factorial-base unranking of a one-based rank into the queue of due elements
    function automatic void queue_permutation(input logic [kpu_pkg::VAL_W-1:0] setting,
                                              input logic [kpu_pkg::RANK_W-1:0] k);
        int                  n;
        int                  p;
        int                  v;
        int                  seen;
        int                  pick;
        bit                  found;
        longint unsigned     total;
        longint unsigned     span;
        longint unsigned     remainder;
        longint unsigned     digit;
        logic [15:0]         used;
        perm_element_t       elem;
        n = (setting > kpu_pkg::MAX_LENGTH_DEF) ? kpu_pkg::MAX_LENGTH_DEF : int'(setting);
        total = 1;
        for (p = 2; p <= n; p++)
            total = total * p;
        if (n == 0 || k == 0 || k > total)
            return;
        remainder = k - 1;
        span      = total;
        used      = '0;
        for (p = 0; p < n; p++)
        begin
            span      = span / (n - p);
            digit     = remainder / span;
            remainder = remainder % span;
            seen      = 0;
            pick      = 0;
            found     = 1'b0;
            for (v = 0; v < n; v++)
            begin
                if (!found && !used[v])
                begin
                    if (seen == digit)
                    begin
                        pick  = v;
                        found = 1'b1;
                    end
                    seen++;
                end
            end
            used[pick]         = 1'b1;
            elem.element_value = kpu_pkg::VAL_W'(pick + 1);
            elem.position      = kpu_pkg::VAL_W'(p);
            elem.is_last       = (p == n - 1);
            due_elements.insert(due_elements.size(), elem);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_setting = 4'd1;
            due_elements.delete();
            fail_count     = 0;
            due_count      = 0;
            checked_count  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_elements.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected element value %0d position %0d last %0b",
                                              element_value, position, last));
                end
                else
                begin
                    want = due_elements.pop_front();
                    if (element_value !== want.element_value)
                        report_mismatch($sformatf("value at position %0d: got %0d, want %0d",
                                                  want.position, element_value,
                                                  want.element_value));
                    if (position !== want.position)
                        report_mismatch($sformatf("position: got %0d, want %0d",
                                                  position, want.position));
                    if (last !== want.is_last)
                        report_mismatch($sformatf("last flag at position %0d: got %0b, want %0b",
                                                  want.position, last, want.is_last));
                    checked_count++;
                end
            end
            if (in_valid && !in_stall)
                queue_permutation(length_setting, rank);
            if (cfg_valid && cfg_ready)
                length_setting = cfg_data;
            due_count = due_elements.size();
        end
    end

endmodule

/* dv/kth_permutation_unrank_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kth_permutation_unrank_tb
// Stimulus and verdict for the permutation unranking unit. A directed part
// covers the rank edges (zero, one, n!, n!+1, all ones), length zero and the
// saturating lengths. Random phases then sweep the length setting with mostly
// in-range ranks and some out-of-range noise. Both sides idle at random.
// The checker instance does all prediction and comparison.
// ----------------------------------------------------------------------------
module kth_permutation_unrank_tb;

    localparam int CLK_HALF      = 4;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_RANKS   = 28;
    localparam int NUM_PHASES    = 16;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [kpu_pkg::VAL_W-1:0]     cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    logic [kpu_pkg::RANK_W-1:0]    rank;
    logic                          out_valid;
    logic                          out_stall;
    logic [kpu_pkg::VAL_W-1:0]     element_value;
    logic [kpu_pkg::VAL_W-1:0]     position;
    logic                          last;

    int mismatches;
    int pending;
    int elements_checked;
    int idle_pct;
    int stall_pct;
    int ranks_sent;
    int settings_used;

    logic [kpu_pkg::VAL_W-1:0] sweep_lengths [NUM_PHASES] =
        '{4'd12, 4'd4, 4'd7, 4'd1, 4'd2, 4'd5, 4'd12, 4'd9,
          4'd14, 4'd3, 4'd6, 4'd11, 4'd8, 4'd10, 4'd13, 4'd12};

    kth_permutation_unrank dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rank          (rank),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .element_value (element_value),
        .position      (position),
        .last          (last)
    );

    kpu_unrank_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .rank             (rank),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .element_value    (element_value),
        .position         (position),
        .last             (last),
        .mismatches       (mismatches),
        .pending          (pending),
        .elements_checked (elements_checked)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    always @(negedge clk)
    begin
        out_stall = ($urandom_range(99) < stall_pct);
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("run exceeded %0d cycles", CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // one rank transaction, held until taken; valid stays high into the next call
    task automatic send_rank(input logic [kpu_pkg::RANK_W-1:0] k);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        rank     = k;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        ranks_sent++;
    endtask

    task automatic drain;
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // length changes only with the unit idle
    task automatic set_length(input logic [kpu_pkg::VAL_W-1:0] len);
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = len;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        settings_used++;
    endtask

    function automatic logic [kpu_pkg::RANK_W-1:0] pick_rank(input logic [kpu_pkg::VAL_W-1:0] len);
        logic [kpu_pkg::FACT_W-1:0] total;
        int                         sel;
        total = kpu_pkg::fact((len > kpu_pkg::MAX_LENGTH_DEF) ? 4'd12 : len);
        sel   = $urandom_range(99);
        if (sel < 80)
            return kpu_pkg::RANK_W'($urandom_range(total, 1));
        else if (sel < 84)
            return (sel[0]) ? kpu_pkg::RANK_W'(total) : kpu_pkg::RANK_W'(1);
        else if (sel < 88)
            return '0;
        else if (sel < 94)
            return kpu_pkg::RANK_W'($urandom_range(32'h7FFF_FFFF, total + 1));
        else
            return kpu_pkg::RANK_W'($urandom());
    endfunction

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        rank          = '0;
        idle_pct      = 24;
        stall_pct     = 24;
        ranks_sent    = 0;
        settings_used = 1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset length of one
        send_rank(31'd0);
        send_rank(31'd1);
        send_rank(31'd2);
        send_rank(31'h7FFF_FFFF);

        set_length(4'd12);
        send_rank(31'd1);
        send_rank(31'd479001600);
        send_rank(31'd479001601);
        send_rank(31'd0);
        send_rank(31'h7FFF_FFFF);
        send_rank(31'd239500801);

        // length zero takes every rank and gives nothing
        set_length(4'd0);
        send_rank(31'd1);
        send_rank(31'd5);

        // saturating length
        set_length(4'd15);
        send_rank(31'd479001600);
        send_rank(31'd1);

        set_length(4'd3);
        for (int k = 1; k <= 7; k++)
            send_rank(kpu_pkg::RANK_W'(k));

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            set_length(sweep_lengths[ph]);
            idle_pct  = (ph == 6 || ph == 7) ? 0 : 24;
            stall_pct = idle_pct;
            for (int i = 0; i < PHASE_RANKS; i++)
            begin
                if (ph == 2 && i == PHASE_RANKS / 2)
                    drain();
                send_rank(pick_rank(sweep_lengths[ph]));
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("covered %0d ranks over %0d length settings with random stalls",
                 ranks_sent, settings_used);
        $display("%0d permutation elements compared, %0d mismatches",
                 elements_checked, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
rtl/kpu_pkg.sv
rtl/kpu_datapath.sv
rtl/kth_permutation_unrank.sv
dv/kpu_unrank_checker.sv
dv/kth_permutation_unrank_tb.sv
